// ===== rtl/morse_beacon_keyer_core_macros.svh =====
// Assertion helpers used by the keyer core RTL.
`ifndef MORSE_BEACON_KEYER_CORE_MACROS_SVH
`define MORSE_BEACON_KEYER_CORE_MACROS_SVH

// Checked on every clock edge while the block is out of reset.
`define MBK_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("keyer check failed");

// Checked on every clock edge, reset included.
`define MBK_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("keyer check failed");

`endif

// ===== rtl/mbk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mbk_pkg;

    localparam int MSG_WIDTH     = 64;
    localparam int LEN_WIDTH     = 6;
    localparam int UNIT_WIDTH    = 3;
    localparam int MAX_SYMBOLS   = 32;
    localparam int SYM_IDX_WIDTH = $clog2(MAX_SYMBOLS);

    localparam logic [MSG_WIDTH-1:0]  MSG_RESET = 64'd12621184;
    localparam logic [LEN_WIDTH-1:0]  LEN_RESET = 6'd12;
    localparam logic [LEN_WIDTH-1:0]  LEN_MAX   = LEN_WIDTH'(MAX_SYMBOLS);

    localparam logic [UNIT_WIDTH-1:0] UNIT_START = 3'd1;
    localparam logic [UNIT_WIDTH-1:0] DASH_UNITS = 3'd3;
    localparam logic [UNIT_WIDTH-1:0] GAP_UNITS  = 3'd2;
    localparam logic [UNIT_WIDTH-1:0] WORD_UNITS = 3'd5;

    typedef enum logic [1:0] {
        SYM_DOT  = 2'd0,
        SYM_DASH = 2'd1,
        SYM_GAP  = 2'd2,
        SYM_WORD = 2'd3
    } t_symbol;

    typedef enum logic {
        REG_MESSAGE_SYMBOLS = 1'b0,
        REG_MESSAGE_LENGTH  = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [LEN_WIDTH-1:0]  position;
        logic [UNIT_WIDTH-1:0] unit_count;
        logic                  lamp;
    } t_keyer_state;

endpackage

`default_nettype wire

// ===== rtl/morse_beacon_keyer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Morse beacon keyer. Every accepted input request is one timer tick; the
// block steps through the stored message of 2-bit symbols and returns one
// result request per tick with the lamp state, the message position and
// whether the lamp was refreshed. A tick is taken in every clock cycle while
// no result waits untaken; its result lands in the output register in the
// cycle after, and new ticks keep being accepted as long as the output side
// takes one result per cycle. The keyer state advances in a single
// registered step per tick. Configuration writes land on the next clock
// edge and must only be made while no tick is in flight.
`include "morse_beacon_keyer_core_macros.svh"

module morse_beacon_keyer_core
    import mbk_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // Tick stream. tdata: [0] restart, [7:1] zero.
    input  wire                  i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  wire [7:0]            i_s_axis_tdata,
    // Result stream. tdata: [0] lamp_on, [6:1] symbol_index, [7] zero.
    output logic                 o_m_axis_tvalid,
    input  wire                  i_m_axis_tready,
    output logic [7:0]           o_m_axis_tdata,
    // tuser: [0] lamp_updated.
    output logic                 o_m_axis_tuser,
    // Configuration writes.
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_addr,
    input  wire [MSG_WIDTH-1:0]  i_cfg_wdata
);

    logic [MSG_WIDTH-1:0] r_symbols;
    logic [LEN_WIDTH-1:0] r_length;
    t_keyer_state         r_state;
    t_keyer_state         n_state;
    logic                 n_updated;
    logic                 r_out_valid;
    logic                 r_out_lamp;
    logic [LEN_WIDTH-1:0] r_out_index;
    logic                 r_out_updated;
    logic                 in_take;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    mbk_step u_step (
        .i_state   (r_state),
        .i_restart (i_s_axis_tdata[0]),
        .i_symbols (r_symbols),
        .i_length  (r_length),
        .o_state   (n_state),
        .o_updated (n_updated)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbols <= MSG_RESET;
            r_length  <= LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_addr))
                REG_MESSAGE_SYMBOLS: r_symbols <= i_cfg_wdata;
                REG_MESSAGE_LENGTH:  r_length  <= i_cfg_wdata[LEN_WIDTH-1:0];
                default:             r_symbols <= r_symbols;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{position: '0, unit_count: UNIT_START, lamp: 1'b0};
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out_lamp    <= n_state.lamp;
            r_out_index   <= n_state.position;
            r_out_updated <= n_updated;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_index, r_out_lamp};
    assign o_m_axis_tuser  = r_out_updated;

    // The position never runs past the longest playable message.
    `MBK_ASSERT(a_index_in_range, o_m_axis_tvalid |-> (r_out_index <= LEN_MAX))
    // A wrap tick always lands back at the start of the message.
    `MBK_ASSERT(a_wrap_to_start, (o_m_axis_tvalid && !o_m_axis_tuser) |-> (r_out_index == '0))
    // Reset leaves the keyer at the start, dark, with no result pending.
    `MBK_ASSERT_ALWAYS(a_reset_state, !i_rst_n |=> (r_state.position == '0
        && r_state.unit_count == UNIT_START && !r_state.lamp && !r_out_valid))

endmodule

`default_nettype wire

// ===== rtl/mbk_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbk_step
    import mbk_pkg::*;
(
    input  wire t_keyer_state         i_state,
    input  wire                       i_restart,
    input  wire [MSG_WIDTH-1:0]       i_symbols,
    input  wire [LEN_WIDTH-1:0]       i_length,
    output t_keyer_state              o_state,
    output logic                      o_updated
);

    logic [LEN_WIDTH-1:0]  eff_len;
    logic [LEN_WIDTH-1:0]  pos;
    logic [LEN_WIDTH-1:0]  pos_inc;
    logic [UNIT_WIDTH-1:0] unit;
    logic [UNIT_WIDTH-1:0] unit_inc;
    logic                  lamp;
    t_symbol               sym;

    always_comb begin
        eff_len  = (i_length > LEN_MAX) ? LEN_MAX : i_length;
        pos      = i_restart ? '0 : i_state.position;
        lamp     = i_restart ? 1'b0 : i_state.lamp;
        unit     = i_state.unit_count;
        pos_inc  = pos + LEN_WIDTH'(1);
        unit_inc = unit + UNIT_WIDTH'(1);
        sym      = t_symbol'(i_symbols[{pos[SYM_IDX_WIDTH-1:0], 1'b0} +: 2]);

        o_state   = '{position: pos, unit_count: unit, lamp: lamp};
        o_updated = 1'b0;

        if (pos >= eff_len) begin
            // Message wrap: no lamp refresh on this tick.
            o_state.position   = '0;
            o_state.unit_count = UNIT_START;
        end else begin
            o_updated = 1'b1;
            unique case (sym)
                SYM_DOT: begin
                    if (lamp) begin
                        o_state.position = pos_inc;
                        o_state.lamp     = 1'b0;
                    end else begin
                        o_state.lamp = 1'b1;
                    end
                end
                SYM_DASH: begin
                    if (!lamp) begin
                        o_state.lamp = 1'b1;
                    end else if (unit == DASH_UNITS) begin
                        o_state.position   = pos_inc;
                        o_state.unit_count = UNIT_START;
                        o_state.lamp       = 1'b0;
                    end else begin
                        o_state.unit_count = unit_inc;
                    end
                end
                SYM_GAP: begin
                    if (unit == GAP_UNITS) begin
                        o_state.position   = pos_inc;
                        o_state.unit_count = UNIT_START;
                    end else begin
                        o_state.unit_count = unit_inc;
                    end
                end
                SYM_WORD: begin
                    if (unit == WORD_UNITS) begin
                        o_state.position   = pos_inc;
                        o_state.unit_count = UNIT_START;
                    end else begin
                        o_state.unit_count = unit_inc;
                    end
                end
                default: begin
                    o_state = i_state;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb
    import mbk_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 64;
    localparam int TICKS_PER_PHASE = 60;
    localparam int RANDOM_PHASES = 10;

    localparam int PAUSE_NONE    = 0;
    localparam int PAUSE_RX_HOLD = 1;
    localparam int PAUSE_DRAIN   = 2;

    typedef struct packed {
        logic                 lamp_on;
        logic [LEN_WIDTH-1:0] symbol_index;
        logic                 lamp_updated;
    } t_tick_result;

    // Keeps its own copy of the keyer state and registers, and queues the
    // result that each accepted tick should produce.
    class keyer_scoreboard;
        logic [MSG_WIDTH-1:0]  msg;
        logic [LEN_WIDTH-1:0]  msg_len;
        logic [LEN_WIDTH-1:0]  pos;
        logic [UNIT_WIDTH-1:0] units;
        logic                  lamp;
        t_tick_result          expected_q[$];
        int                    errors;
        int                    checked;
        int                    wraps;
        int                    restarts;

        function new();
            msg      = MSG_RESET;
            msg_len  = LEN_RESET;
            pos      = '0;
            units    = UNIT_START;
            lamp     = 1'b0;
            errors   = 0;
            checked  = 0;
            wraps    = 0;
            restarts = 0;
        endfunction

        function void write_reg(t_reg_index idx, logic [MSG_WIDTH-1:0] value);
            if (idx == REG_MESSAGE_SYMBOLS)
                msg = value;
            else
                msg_len = value[LEN_WIDTH-1:0];
        endfunction

        function void advance_symbol();
            pos   = pos + 1'b1;
            units = UNIT_START;
        endfunction

        function void note_tick(logic restart);
            logic [LEN_WIDTH-1:0] span;
            t_symbol              sym;
            t_tick_result         want;
            want.lamp_updated = 1'b0;
            if (restart) begin
                pos  = '0;
                lamp = 1'b0;
                restarts++;
            end
            // Lengths past the symbol store play the whole store.
            span = (msg_len > LEN_MAX) ? LEN_MAX : msg_len;
            if (pos >= span) begin
                pos   = '0;
                units = UNIT_START;
                wraps++;
            end else begin
                sym = t_symbol'(msg[2 * int'(pos) +: 2]);
                want.lamp_updated = 1'b1;
                case (sym)
                    SYM_DOT: begin
                        if (lamp) begin
                            pos  = pos + 1'b1;
                            lamp = 1'b0;
                        end else begin
                            lamp = 1'b1;
                        end
                    end
                    SYM_DASH: begin
                        if (!lamp) begin
                            lamp = 1'b1;
                        end else if (units == DASH_UNITS) begin
                            advance_symbol();
                            lamp = 1'b0;
                        end else begin
                            units = units + 1'b1;
                        end
                    end
                    SYM_GAP: begin
                        if (units == GAP_UNITS)
                            advance_symbol();
                        else
                            units = units + 1'b1;
                    end
                    default: begin
                        if (units == WORD_UNITS)
                            advance_symbol();
                        else
                            units = units + 1'b1;
                    end
                endcase
            end
            want.lamp_on      = lamp;
            want.symbol_index = pos;
            expected_q.push_back(want);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(logic lamp_on, logic [LEN_WIDTH-1:0] symbol_index,
                                   logic lamp_updated);
            t_tick_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with no tick waiting, actual lamp %0d index %0d upd %0d",
                         $time, lamp_on, symbol_index, lamp_updated);
            end else begin
                want = expected_q.pop_front();
                checked++;
                compare_field("lamp_on", 8'(want.lamp_on), 8'(lamp_on));
                compare_field("symbol_index", 8'(want.symbol_index), 8'(symbol_index));
                compare_field("lamp_updated", 8'(want.lamp_updated), 8'(lamp_updated));
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;
    logic                 m_tuser;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_addr  = 1'b0;
    logic [MSG_WIDTH-1:0] cfg_wdata = '0;

    keyer_scoreboard sb;
    bit              no_idle     = 1'b0;
    bit              rx_hold_req = 1'b0;
    int              rx_stall    = 0;
    int              idle_cycles = 0;
    int              settings    = 0;

    always #10 clk = ~clk;

    morse_beacon_keyer_core uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random stalls, plus one long hold-off when asked.
    always begin
        @(negedge clk);
        if (rx_hold_req) begin
            m_tready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(negedge clk);
            rx_hold_req = 1'b0;
        end else if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_tready <= 1'b1;
            rx_stall = no_idle ? 0 : pick_gap();
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[0], m_tdata[LEN_WIDTH:1], m_tuser);
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_tick(input logic restart, input int gap);
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        do @(posedge clk); while (!s_tready);
        sb.note_tick(restart);
    endtask

    // Drop the tick stream and wait until every queued result has come back.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    task automatic write_cfg(input t_reg_index idx, input logic [MSG_WIDTH-1:0] value);
        drain_results();
        repeat (2) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic set_message(input logic [MSG_WIDTH-1:0] symbols,
                               input logic [MSG_WIDTH-1:0] msg_len);
        write_cfg(REG_MESSAGE_SYMBOLS, symbols);
        write_cfg(REG_MESSAGE_LENGTH, msg_len);
        settings++;
    endtask

    task automatic run_ticks(input int count, input int restart_odds, input int pause_mode);
        int gap;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                if (pause_mode == PAUSE_DRAIN)
                    drain_results();
                else if (pause_mode == PAUSE_RX_HOLD)
                    rx_hold_req = 1'b1;
            end
            gap = (no_idle || rx_hold_req) ? 0 : pick_gap();
            send_tick($urandom_range(0, restart_odds - 1) == 0, gap);
        end
    endtask

    initial begin
        sb = new();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Default message: the opening dots light and darken the lamp in turn.
        for (int i = 0; i < 5; i++)
            send_tick(1'b0, 0);

        // Dash then word gap. A restart in the word gap leaves the unit count
        // at four, so the following dash counts through the 3-bit wrap.
        set_message(MSG_WIDTH'({SYM_WORD, SYM_DASH}), MSG_WIDTH'(2));
        send_tick(1'b1, 0);
        for (int i = 0; i < 6; i++)
            send_tick(1'b0, 0);
        send_tick(1'b1, 0);
        for (int i = 0; i < 8; i++)
            send_tick(1'b0, pick_gap());

        // Zero length while the position sits past it: wrap ticks only.
        write_cfg(REG_MESSAGE_LENGTH, MSG_WIDTH'(0));
        settings++;
        send_tick(1'b0, 0);
        send_tick(1'b1, 0);

        // Length above the store size, all word gaps.
        set_message({32{SYM_WORD}}, MSG_WIDTH'(63));
        send_tick(1'b0, 0);
        send_tick(1'b0, 0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            no_idle = (phase == 2 || phase == 7);
            case (phase)
                0: begin
                    set_message({$urandom(), $urandom()}, MSG_WIDTH'(LEN_MAX));
                    run_ticks(TICKS_PER_PHASE, 20, PAUSE_RX_HOLD);
                end
                1: begin
                    set_message({32{SYM_DOT}}, MSG_WIDTH'(1));
                    run_ticks(TICKS_PER_PHASE, 4, PAUSE_NONE);
                end
                2: begin
                    set_message({32{SYM_WORD}}, MSG_WIDTH'(63));
                    run_ticks(TICKS_PER_PHASE, 12, PAUSE_NONE);
                end
                3: begin
                    set_message({32{SYM_DASH}}, MSG_WIDTH'(33));
                    run_ticks(TICKS_PER_PHASE, 3, PAUSE_DRAIN);
                end
                5: begin
                    set_message({$urandom(), $urandom()}, MSG_WIDTH'(0));
                    run_ticks(TICKS_PER_PHASE, 10, PAUSE_NONE);
                end
                6: begin
                    set_message(MSG_RESET, MSG_WIDTH'(LEN_RESET));
                    run_ticks(TICKS_PER_PHASE, 30, PAUSE_NONE);
                end
                7: begin
                    set_message({$urandom(), $urandom()},
                                MSG_WIDTH'($urandom_range(1, int'(LEN_MAX))));
                    run_ticks(TICKS_PER_PHASE, 15, PAUSE_NONE);
                end
                9: begin
                    set_message({$urandom(), $urandom()}, MSG_WIDTH'(LEN_MAX));
                    run_ticks(TICKS_PER_PHASE, 8, PAUSE_NONE);
                end
                default: begin
                    set_message({$urandom(), $urandom()}, MSG_WIDTH'($urandom_range(0, 63)));
                    run_ticks(TICKS_PER_PHASE, 10, PAUSE_NONE);
                end
            endcase
        end

        drain_results();
        repeat (4) @(posedge clk);

        $display("Covered %0d ticks over %0d message settings, with %0d wraps and %0d restarts,",
                 sb.checked, settings, sb.wraps, sb.restarts);
        $display("including one long result-side hold-off and one drain pause on the tick side.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== morse_beacon_keyer_core.f =====
+incdir+rtl
rtl/mbk_pkg.sv
rtl/mbk_step.sv
rtl/morse_beacon_keyer_core.sv
bench/tb.sv
